@@ hw/rtl/esc_pkg.sv @@
package esc_pkg;

  localparam int unsigned CoordW = 48;
  localparam int unsigned RadW = 47;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned RsumW = RadW + 1;
  localparam int unsigned TimeW = 43;
  localparam int unsigned IdxW = 8;
  localparam int unsigned QuadW = 100;
  localparam int unsigned MulAW = 144;
  localparam int unsigned DigW = 8;
  localparam int unsigned MulDigits = 13;
  localparam int unsigned MulBW = MulDigits * DigW;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned NdigW = 4;
  localparam int unsigned FracW = 16;

  localparam logic [TimeW-1:0] TimeCap = 43'd6553600000000;
  localparam int unsigned MaxBodies = 256;
  localparam int unsigned FifoDepth = 2;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegPosX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPosY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPosZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVelX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVelY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVelZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRadius = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] other_pos_x;
    logic signed [CoordW-1:0] other_pos_y;
    logic signed [CoordW-1:0] other_pos_z;
    logic signed [CoordW-1:0] other_vel_x;
    logic signed [CoordW-1:0] other_vel_y;
    logic signed [CoordW-1:0] other_vel_z;
    logic [RadW-1:0]          other_radius;
    logic                     last_body;
  } esc_in_t;

  typedef struct packed {
    logic                     hit;
    logic [TimeW-1:0]         hit_time;
    logic signed [CoordW-1:0] impact_x;
    logic signed [CoordW-1:0] impact_y;
    logic signed [CoordW-1:0] impact_z;
    logic [IdxW-1:0]          hit_index;
  } esc_out_t;

  // one preprocessed body handed from front to back
  typedef struct packed {
    logic [DiffW-1:0] av_x;
    logic [DiffW-1:0] av_y;
    logic [DiffW-1:0] av_z;
    logic [DiffW-1:0] bv_x;
    logic [DiffW-1:0] bv_y;
    logic [DiffW-1:0] bv_z;
    logic [RsumW-1:0] rsum;
    logic [DiffW-1:0] psum_x;
    logic [DiffW-1:0] psum_y;
    logic [DiffW-1:0] psum_z;
    logic [DiffW-1:0] vsum_x;
    logic [DiffW-1:0] vsum_y;
    logic [DiffW-1:0] vsum_z;
    logic [IdxW-1:0]  idx;
    logic             last;
  } esc_job_t;

endpackage

@@ hw/rtl/esc_mul.sv @@
module esc_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [esc_pkg::MulAW-1:0]   a_i,
  input  logic signed [esc_pkg::MulBW-1:0]   b_i,
  input  logic [esc_pkg::NdigW-1:0]          nd_i,
  output logic                               done_o,
  output logic signed [esc_pkg::ProdW-1:0]   prod_o
);

  localparam int unsigned ShW = esc_pkg::NdigW + 3;
  localparam logic [esc_pkg::NdigW-1:0] DigitsN = esc_pkg::NdigW'(esc_pkg::MulDigits);

  logic signed [esc_pkg::MulAW-1:0] a_q;
  logic signed [esc_pkg::MulBW-1:0] b_q;
  logic signed [esc_pkg::ProdW-1:0] acc_q;
  logic [esc_pkg::NdigW-1:0]        cnt_q;
  logic                             busy_q;
  logic                             first_q;
  logic                             done_q;

  logic signed [esc_pkg::DigW:0]         dig;
  logic signed [esc_pkg::MulAW+esc_pkg::DigW:0] pp;
  logic signed [esc_pkg::ProdW-1:0]      acc_d;
  logic [ShW-1:0]                        sh_amt;

  // top digit carries the sign, lower digits are unsigned
  always_comb begin
    if (first_q) begin
      dig = {b_q[esc_pkg::MulBW-1], b_q[esc_pkg::MulBW-1 -: esc_pkg::DigW]};
    end else begin
      dig = {1'b0, b_q[esc_pkg::MulBW-1 -: esc_pkg::DigW]};
    end
    pp     = a_q * dig;
    acc_d  = (acc_q <<< esc_pkg::DigW) + esc_pkg::ProdW'(pp);
    sh_amt = ShW'(DigitsN - nd_i) * ShW'(esc_pkg::DigW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // align the top used digit to the MSB end
        a_q     <= a_i;
        b_q     <= b_i << sh_amt;
        cnt_q   <= nd_i;
        acc_q   <= '0;
        busy_q  <= 1'b1;
        first_q <= 1'b1;
      end else if (busy_q) begin
        acc_q   <= acc_d;
        b_q     <= b_q << esc_pkg::DigW;
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == esc_pkg::NdigW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ hw/rtl/esc_fifo.sv @@
module esc_fifo #(
  parameter int unsigned Depth = esc_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  esc_pkg::esc_job_t din_i,
  output logic              full_o,
  input  logic              rd_i,
  output esc_pkg::esc_job_t dout_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  esc_pkg::esc_job_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/esc_front.sv @@
module esc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  esc_pkg::esc_in_t                item_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [esc_pkg::CoordW-1:0]      cfg_data_i,
  input  logic                            fifo_full_i,
  output logic                            wr_o,
  output esc_pkg::esc_job_t               job_o
);

  localparam int unsigned CntW = esc_pkg::IdxW + 1;
  localparam logic [CntW-1:0] WrapAt =
    CntW'((esc_pkg::MaxBodies < 256) ? esc_pkg::MaxBodies : 256);

  logic [esc_pkg::CoordW-1:0] sp_x_q, sp_y_q, sp_z_q;
  logic [esc_pkg::CoordW-1:0] sv_x_q, sv_y_q, sv_z_q;
  logic [esc_pkg::RadW-1:0]   rad_q;
  logic [esc_pkg::IdxW-1:0]   cnt_q;
  logic [CntW-1:0]            cnt_inc;

  assign cfg_ready_o = 1'b1;
  assign wr_o        = push_i & ~fifo_full_i;
  assign cnt_inc     = {1'b0, cnt_q} + CntW'(1);

  always_comb begin
    job_o.av_x   = {item_i.other_vel_x[47], item_i.other_vel_x} - {sv_x_q[47], sv_x_q};
    job_o.av_y   = {item_i.other_vel_y[47], item_i.other_vel_y} - {sv_y_q[47], sv_y_q};
    job_o.av_z   = {item_i.other_vel_z[47], item_i.other_vel_z} - {sv_z_q[47], sv_z_q};
    job_o.bv_x   = {item_i.other_pos_x[47], item_i.other_pos_x} - {sp_x_q[47], sp_x_q};
    job_o.bv_y   = {item_i.other_pos_y[47], item_i.other_pos_y} - {sp_y_q[47], sp_y_q};
    job_o.bv_z   = {item_i.other_pos_z[47], item_i.other_pos_z} - {sp_z_q[47], sp_z_q};
    job_o.rsum   = {1'b0, item_i.other_radius} + {1'b0, rad_q};
    job_o.psum_x = {item_i.other_pos_x[47], item_i.other_pos_x} + {sp_x_q[47], sp_x_q};
    job_o.psum_y = {item_i.other_pos_y[47], item_i.other_pos_y} + {sp_y_q[47], sp_y_q};
    job_o.psum_z = {item_i.other_pos_z[47], item_i.other_pos_z} + {sp_z_q[47], sp_z_q};
    job_o.vsum_x = {item_i.other_vel_x[47], item_i.other_vel_x} + {sv_x_q[47], sv_x_q};
    job_o.vsum_y = {item_i.other_vel_y[47], item_i.other_vel_y} + {sv_y_q[47], sv_y_q};
    job_o.vsum_z = {item_i.other_vel_z[47], item_i.other_vel_z} + {sv_z_q[47], sv_z_q};
    job_o.idx    = cnt_q;
    job_o.last   = item_i.last_body;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_x_q <= '0;
      sp_y_q <= '0;
      sp_z_q <= '0;
      sv_x_q <= '0;
      sv_y_q <= '0;
      sv_z_q <= '0;
      rad_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          esc_pkg::RegPosX:   sp_x_q <= cfg_data_i;
          esc_pkg::RegPosY:   sp_y_q <= cfg_data_i;
          esc_pkg::RegPosZ:   sp_z_q <= cfg_data_i;
          esc_pkg::RegVelX:   sv_x_q <= cfg_data_i;
          esc_pkg::RegVelY:   sv_y_q <= cfg_data_i;
          esc_pkg::RegVelZ:   sv_z_q <= cfg_data_i;
          esc_pkg::RegRadius: rad_q  <= cfg_data_i[esc_pkg::RadW-1:0];
          default: ;
        endcase
      end
      if (wr_o) begin
        // restart the scan count on the last body or at the wrap point
        if (item_i.last_body || cnt_inc >= WrapAt) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_inc[esc_pkg::IdxW-1:0];
        end
      end
    end
  end

endmodule

@@ hw/rtl/esc_back.sv @@
module esc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  esc_pkg::esc_job_t job_i,
  output logic              job_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output esc_pkg::esc_out_t result_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_CLASS, ST_DH, ST_DAC, ST_PU, ST_PG,
    ST_SNEXT, ST_CMP, ST_MID, ST_UPD, ST_EMIT
  } state_e;

  localparam int unsigned AW = esc_pkg::MulAW;
  localparam int unsigned BW = esc_pkg::MulBW;
  localparam int unsigned PW = esc_pkg::ProdW;
  localparam int unsigned QW = esc_pkg::QuadW;
  localparam int unsigned TW = esc_pkg::TimeW;
  localparam int unsigned CW = esc_pkg::CoordW;
  localparam int unsigned NW = esc_pkg::NdigW;

  localparam logic [NW-1:0] NdDiff = NW'(7);
  localparam logic [NW-1:0] NdQuad = NW'(esc_pkg::MulDigits);
  localparam logic [NW-1:0] NdTime = NW'(6);
  localparam logic [3:0]    LastOp = 4'd9;

  state_e state_q;
  esc_pkg::esc_job_t job_q;
  logic [3:0]            op_q;
  logic                  wait_q;
  logic signed [QW-1:0]  a_q, h_q, c_q;
  logic signed [PW-1:0]  x_q;
  logic signed [AW-1:0]  w_q;
  logic                  entry_q, first_q, vle0_q, ok_q;
  logic [TW-1:0]         lo_q, hi_q, t_q, tres_q;
  logic [1:0]            k_q;
  logic [CW-1:0]         imp_x_q, imp_y_q, imp_z_q;
  logic [TW-1:0]         best_time_q;
  logic [CW-1:0]         best_x_q, best_y_q, best_z_q;
  logic [esc_pkg::IdxW-1:0] best_idx_q;
  logic                  found_q;
  logic                  out_valid_q;
  esc_pkg::esc_out_t     out_q;

  logic                  mul_go, mul_done;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic [NW-1:0]         mul_nd;
  logic signed [PW-1:0]  mul_p;
  logic signed [QW-1:0]  prod_lo;
  logic signed [AW-1:0]  u, v, w;
  logic signed [PW-1:0]  g, d, s, sh;
  logic                  pred;
  logic [TW-1:0]         span, nxt_t;
  logic [esc_pkg::DiffW-1:0] psum_k, vsum_k;
  logic [PW-CW:0]        sh_top;
  logic [CW-1:0]         sat;

  function automatic logic signed [AW-1:0] ext_a(logic signed [esc_pkg::DiffW-1:0] x);
    return AW'(x);
  endfunction

  function automatic logic signed [BW-1:0] ext_b(logic signed [esc_pkg::DiffW-1:0] x);
    return BW'(x);
  endfunction

  esc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .nd_i   (mul_nd),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  assign job_rd_o = (state_q == ST_IDLE) & ~job_empty_i;
  assign empty_o  = ~out_valid_q;
  assign result_o = out_q;

  always_comb begin
    mul_go = ~wait_q & ((state_q == ST_PREP) | (state_q == ST_DH) | (state_q == ST_DAC) |
                        (state_q == ST_PU) | (state_q == ST_PG) | (state_q == ST_MID));
    mul_a  = '0;
    mul_b  = '0;
    mul_nd = NdTime;
    case (k_q)
      2'd0: begin
        psum_k = job_q.psum_x;
        vsum_k = job_q.vsum_x;
      end
      2'd1: begin
        psum_k = job_q.psum_y;
        vsum_k = job_q.vsum_y;
      end
      default: begin
        psum_k = job_q.psum_z;
        vsum_k = job_q.vsum_z;
      end
    endcase
    case (state_q)
      ST_PREP: begin
        mul_nd = NdDiff;
        case (op_q)
          4'd0: begin mul_a = ext_a(job_q.av_x); mul_b = ext_b(job_q.av_x); end
          4'd1: begin mul_a = ext_a(job_q.av_y); mul_b = ext_b(job_q.av_y); end
          4'd2: begin mul_a = ext_a(job_q.av_z); mul_b = ext_b(job_q.av_z); end
          4'd3: begin mul_a = ext_a(job_q.av_x); mul_b = ext_b(job_q.bv_x); end
          4'd4: begin mul_a = ext_a(job_q.av_y); mul_b = ext_b(job_q.bv_y); end
          4'd5: begin mul_a = ext_a(job_q.av_z); mul_b = ext_b(job_q.bv_z); end
          4'd6: begin mul_a = ext_a(job_q.bv_x); mul_b = ext_b(job_q.bv_x); end
          4'd7: begin mul_a = ext_a(job_q.bv_y); mul_b = ext_b(job_q.bv_y); end
          4'd8: begin mul_a = ext_a(job_q.bv_z); mul_b = ext_b(job_q.bv_z); end
          default: begin
            mul_a = AW'({1'b0, job_q.rsum});
            mul_b = BW'({1'b0, job_q.rsum});
          end
        endcase
      end
      ST_DH: begin
        mul_a  = AW'(h_q);
        mul_b  = BW'(h_q);
        mul_nd = NdQuad;
      end
      ST_DAC: begin
        mul_a  = AW'(a_q);
        mul_b  = BW'(c_q);
        mul_nd = NdQuad;
      end
      ST_PU: begin
        mul_a = AW'(a_q);
        mul_b = BW'({1'b0, t_q});
      end
      ST_PG: begin
        mul_a = w_q;
        mul_b = BW'({1'b0, t_q});
      end
      ST_MID: begin
        mul_a = ext_a(vsum_k);
        mul_b = BW'({1'b0, tres_q});
      end
      default: ;
    endcase

    prod_lo = mul_p[QW-1:0];
    // Horner form: g(t) = (a*t + 2h*2^16)*t + c*2^32
    u   = mul_p[AW-1:0];
    v   = u + (AW'(h_q) <<< esc_pkg::FracW);
    w   = u + (AW'(h_q) <<< (esc_pkg::FracW + 1));
    g   = mul_p + (PW'(c_q) <<< (2 * esc_pkg::FracW));
    d   = x_q - mul_p;
    if (entry_q) begin
      pred = ~g[PW-1] & vle0_q;
    end else begin
      pred = g[PW-1] | (g == '0);
    end
    span  = hi_q - lo_q;
    nxt_t = lo_q + (span >> 1);

    // midpoint: floor((psum*2^16 + vsum*t) / 2^17), saturated
    s      = mul_p + (PW'($signed(psum_k)) <<< esc_pkg::FracW);
    sh     = s >>> (esc_pkg::FracW + 1);
    sh_top = sh[PW-1:CW-1];
    if ((sh_top == '0) || (sh_top == '1)) begin
      sat = sh[CW-1:0];
    end else if (sh[PW-1]) begin
      sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= '0;
      op_q        <= '0;
      wait_q      <= 1'b0;
      a_q         <= '0;
      h_q         <= '0;
      c_q         <= '0;
      x_q         <= '0;
      w_q         <= '0;
      entry_q     <= 1'b0;
      first_q     <= 1'b0;
      vle0_q      <= 1'b0;
      ok_q        <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      t_q         <= '0;
      tres_q      <= '0;
      k_q         <= '0;
      imp_x_q     <= '0;
      imp_y_q     <= '0;
      imp_z_q     <= '0;
      best_time_q <= esc_pkg::TimeCap;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_z_q    <= '0;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (mul_go) begin
        wait_q <= 1'b1;
      end else if (mul_done) begin
        wait_q <= 1'b0;
      end
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            a_q     <= '0;
            h_q     <= '0;
            c_q     <= '0;
            op_q    <= '0;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (mul_done) begin
            if (op_q < 4'd3) begin
              a_q <= a_q + prod_lo;
            end else if (op_q < 4'd6) begin
              h_q <= h_q + prod_lo;
            end else if (op_q < LastOp) begin
              c_q <= c_q + prod_lo;
            end else begin
              c_q <= c_q - prod_lo;
            end
            if (op_q == LastOp) begin
              state_q <= ST_CLASS;
            end else begin
              op_q <= op_q + 1'b1;
            end
          end
        end
        ST_CLASS: begin
          if (a_q == '0) begin
            ok_q    <= 1'b0;
            state_q <= ST_CMP;
          end else if (c_q == '0) begin
            ok_q    <= 1'b1;
            tres_q  <= '0;
            state_q <= ST_CMP;
          end else if (c_q[QW-1]) begin
            // overlapping now: search for the separation time
            entry_q <= 1'b0;
            first_q <= 1'b1;
            lo_q    <= '0;
            hi_q    <= esc_pkg::TimeCap;
            t_q     <= esc_pkg::TimeCap;
            state_q <= ST_PU;
          end else if (h_q[QW-1]) begin
            state_q <= ST_DH;
          end else begin
            ok_q    <= 1'b0;
            state_q <= ST_CMP;
          end
        end
        ST_DH: begin
          if (mul_done) begin
            x_q     <= mul_p;
            state_q <= ST_DAC;
          end
        end
        ST_DAC: begin
          if (mul_done) begin
            if (d[PW-1]) begin
              ok_q    <= 1'b0;
              state_q <= ST_CMP;
            end else begin
              entry_q <= 1'b1;
              first_q <= 1'b1;
              lo_q    <= '0;
              hi_q    <= esc_pkg::TimeCap;
              t_q     <= esc_pkg::TimeCap;
              state_q <= ST_PU;
            end
          end
        end
        ST_PU: begin
          if (mul_done) begin
            vle0_q  <= v[AW-1] | (v == '0);
            w_q     <= w;
            state_q <= ST_PG;
          end
        end
        ST_PG: begin
          if (mul_done) begin
            if (first_q) begin
              first_q <= 1'b0;
              if (pred) begin
                ok_q    <= 1'b0;
                state_q <= ST_CMP;
              end else begin
                state_q <= ST_SNEXT;
              end
            end else begin
              if (pred) begin
                lo_q <= t_q;
              end else begin
                hi_q <= t_q;
              end
              state_q <= ST_SNEXT;
            end
          end
        end
        ST_SNEXT: begin
          if (span > TW'(1)) begin
            t_q     <= nxt_t;
            state_q <= ST_PU;
          end else begin
            tres_q  <= lo_q;
            ok_q    <= 1'b1;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (ok_q && (tres_q < best_time_q)) begin
            k_q     <= '0;
            state_q <= ST_MID;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_MID: begin
          if (mul_done) begin
            case (k_q)
              2'd0:    imp_x_q <= sat;
              2'd1:    imp_y_q <= sat;
              default: imp_z_q <= sat;
            endcase
            if (k_q == 2'd2) begin
              state_q <= ST_UPD;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        ST_UPD: begin
          best_time_q <= tres_q;
          best_x_q    <= imp_x_q;
          best_y_q    <= imp_y_q;
          best_z_q    <= imp_z_q;
          best_idx_q  <= job_q.idx;
          found_q     <= 1'b1;
          state_q     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!job_q.last) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q) begin
            // hold until the result register frees, then start a new scan
            out_valid_q       <= 1'b1;
            out_q.hit         <= found_q;
            out_q.hit_time    <= best_time_q;
            out_q.impact_x    <= best_x_q;
            out_q.impact_y    <= best_y_q;
            out_q.impact_z    <= best_z_q;
            out_q.hit_index   <= best_idx_q;
            best_time_q       <= esc_pkg::TimeCap;
            best_x_q          <= '0;
            best_y_q          <= '0;
            best_z_q          <= '0;
            best_idx_q        <= '0;
            found_q           <= 1'b0;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/earliest_sphere_collision_unit.sv @@
// Each body is set up and classified in the back end; some bodies add a discriminant
// check or a bisection search over the 43 time bits, and a body that sets a new best
// also works out its impact point.
// The back end works on one body at a time; all products go through one shared
// 144x9-bit digit-serial multiplier.
// Reset (asynchronous, active low) clears configuration to zero, the scan state
// and the queues; there is no clearing pass.
module earliest_sphere_collision_unit #(
  parameter int unsigned FIFO_DEPTH = esc_pkg::FifoDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  esc_pkg::esc_in_t            item_i,
  output logic                        empty,
  input  logic                        pop,
  output esc_pkg::esc_out_t           result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [esc_pkg::CoordW-1:0]  cfg_data_i
);

  logic              wr, rd, fifo_empty;
  esc_pkg::esc_job_t job_in, job_out;

  esc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fifo_full_i(full),
    .wr_o       (wr),
    .job_o      (job_in)
  );

  esc_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .din_i  (job_in),
    .full_o (full),
    .rd_i   (rd),
    .dout_o (job_out),
    .empty_o(fifo_empty)
  );

  esc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(fifo_empty),
    .job_i      (job_out),
    .job_rd_o   (rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

endmodule
